FILE: hdl/hbd_pkg.sv
// Package for the Huffman tree build and bit decode core.
// Holds the channel payload structs, action and status codes, and tree constants.
// No dependencies.
package hbd_pkg;

  // Length table size, fixed by the 5-bit symbol index.
  localparam int LEN_ENTRIES = 32;
  // Scaled Kraft sum: up to 32 terms of at most 2^30.
  localparam int SUM_W       = 36;
  // Child entry: leaf mark in the top bit, symbol or node index below.
  localparam int CHILD_W     = 8;
  localparam int LEAF_BIT    = 7;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_SINGLE = 2'd2,
    ACT_DECODE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD     = 2'd1,
    STAT_NO_TREE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] symbol_index;
    logic [4:0] code_length;
    logic [5:0] symbol_count;
    logic [4:0] min_depth;
    logic [4:0] max_depth;
    logic       code_bit;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       symbol_valid;
    logic [4:0] symbol;
    logic       bit_used;
  } out_t;

endpackage

FILE: hdl/hbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/huffman_tree_build_and_bit_decode_core.sv
// Huffman tree build and bit decode core: load, build, set-single and decode beats.
// Load and set-single finish on acceptance. Decode through the tree waits on the
// registered child RAM read; decode with no tree or a leaf root finishes on
// acceptance. Build: bad parameters finish on acceptance, else a length check, the
// min_depth chain, then a scan of the length table per depth plus climb (through
// S_CLIMB and S_CLIMB_WAIT per level) and descend steps. One beat is in flight at
// a time. Synchronous active-low reset clears the length table and tree status;
// the tree RAMs hold no reset value.
module huffman_tree_build_and_bit_decode_core #(
  parameter int NUM_SYMBOLS = 32,
  parameter int DEPTH_LIMIT = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hbd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hbd_pkg::out_t out_data
);
  import hbd_pkg::*;

  localparam int NI    = $clog2(NUM_SYMBOLS);
  localparam int NW    = $clog2(NUM_SYMBOLS + 1);
  localparam int RDEP  = 2 * (1 << NI);
  localparam logic [7:0]    NUM8  = 8'(NUM_SYMBOLS);
  localparam logic [NW-1:0] NUMW  = NW'(NUM_SYMBOLS);
  localparam logic [4:0]    DLIM  = 5'(DEPTH_LIMIT);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_VAL        = 8'b0000_0010,
    S_CHAIN      = 8'b0000_0100,
    S_SCAN       = 8'b0000_1000,
    S_CLIMB      = 8'b0001_0000,
    S_CLIMB_WAIT = 8'b0010_0000,
    S_DESC       = 8'b0100_0000,
    S_DEC_WAIT   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [5:0]        i_r, i_nxt;
  logic [5:0]        end_r, end_nxt;
  logic [4:0]        d_r, d_nxt;
  logic [4:0]        mind_r, mind_nxt;
  logic [4:0]        maxd_r, maxd_nxt;
  logic              bit_r, bit_nxt;
  logic [NW-1:0]     curr_r, curr_nxt;
  logic [NW-1:0]     empty_r, empty_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [NUM_SYMBOLS-1:0] lc_set_r, lc_set_nxt;
  logic [NUM_SYMBOLS-1:0] rc_set_r, rc_set_nxt;
  logic              bank_r, bank_nxt;
  logic              root_leaf_r, root_leaf_nxt;
  logic [4:0]        root_sym_r, root_sym_nxt;
  logic [NI-1:0]     walk_r, walk_nxt;
  logic              ready_r, ready_nxt;
  logic [4:0]        len_r [LEN_ENTRIES];
  logic [4:0]        len_nxt [LEN_ENTRIES];
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Result of the current beat
  logic              fin;
  out_t              res;

  // RAM ports
  logic               lc_we, rc_we, pn_we;
  logic [NI-1:0]      lc_node, rc_node, pn_waddr;
  logic [CHILD_W-1:0] lc_wdata, rc_wdata, lc_rdata, rc_rdata;
  logic [NI-1:0]      pn_wdata, pn_rdata;

  // Working values
  logic [4:0]         len_cur;
  logic [SUM_W-1:0]   term, target;
  logic [7:0]         cnt8;
  logic [7:0]         i8;
  logic [NI-1:0]      curr_ix, empty_ix;
  logic [NW-1:0]      e1;
  logic [CHILD_W-1:0] leaf_val, empty_val, child;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign len_cur   = len_r[i_r[4:0]];
  assign term      = SUM_W'(1) << (maxd_r - len_cur);
  assign target    = SUM_W'(1) << maxd_r;
  assign i8        = {2'b00, i_r};
  assign curr_ix   = curr_r[NI-1:0];
  assign empty_ix  = empty_r[NI-1:0];
  assign e1        = empty_r + NW'(1);
  assign leaf_val  = {1'b1, 2'b00, i_r[4:0]};
  assign empty_val = {1'b0, 7'(empty_r)};
  assign child     = bit_r ? rc_rdata : lc_rdata;

  // Tree RAMs: decode reads the committed bank, build writes the other one
  hbd_ram #(.W(CHILD_W), .DEPTH(RDEP)) u_lc_ram (
    .clk   (clk),
    .we    (lc_we),
    .waddr ({~bank_r, lc_node}),
    .wdata (lc_wdata),
    .raddr ({bank_r, walk_r}),
    .rdata (lc_rdata)
  );

  hbd_ram #(.W(CHILD_W), .DEPTH(RDEP)) u_rc_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr ({~bank_r, rc_node}),
    .wdata (rc_wdata),
    .raddr ({bank_r, walk_r}),
    .rdata (rc_rdata)
  );

  hbd_ram #(.W(NI), .DEPTH(1 << NI)) u_pn_ram (
    .clk   (clk),
    .we    (pn_we),
    .waddr (pn_waddr),
    .wdata (pn_wdata),
    .raddr (curr_ix),
    .rdata (pn_rdata)
  );

  // Sequencer: accept, check, build, climb, descend and decode
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    end_nxt       = end_r;
    d_nxt         = d_r;
    mind_nxt      = mind_r;
    maxd_nxt      = maxd_r;
    bit_nxt       = bit_r;
    curr_nxt      = curr_r;
    empty_nxt     = empty_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    lc_set_nxt    = lc_set_r;
    rc_set_nxt    = rc_set_r;
    bank_nxt      = bank_r;
    root_leaf_nxt = root_leaf_r;
    root_sym_nxt  = root_sym_r;
    walk_nxt      = walk_r;
    ready_nxt     = ready_r;
    len_nxt       = len_r;
    fin           = 1'b0;
    res           = '0;
    res.status    = STAT_OK;
    lc_we         = 1'b0;
    rc_we         = 1'b0;
    pn_we         = 1'b0;
    lc_node       = curr_ix;
    rc_node       = curr_ix;
    pn_waddr      = empty_ix;
    lc_wdata      = leaf_val;
    rc_wdata      = leaf_val;
    pn_wdata      = curr_ix;
    cnt8          = {2'b00, in_data.symbol_count};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.action)
            ACT_LOAD: begin
              fin = 1'b1;
              if ({3'b000, in_data.symbol_index} < NUM8) begin
                len_nxt[in_data.symbol_index] = in_data.code_length;
              end
            end
            ACT_BUILD: begin
              mind_nxt = in_data.min_depth;
              maxd_nxt = in_data.max_depth;
              if (cnt8 > NUM8) cnt8 = NUM8;
              if (cnt8 > 8'(LEN_ENTRIES)) cnt8 = 8'(LEN_ENTRIES);
              end_nxt  = cnt8[5:0];
              if (in_data.min_depth == 5'd0 || in_data.max_depth > DLIM ||
                  in_data.min_depth > in_data.max_depth ||
                  in_data.symbol_count == 6'd0) begin
                fin        = 1'b1;
                res.status = STAT_BAD;
              end else begin
                i_nxt      = '0;
                sum_nxt    = '0;
                lc_set_nxt = '0;
                rc_set_nxt = '0;
                state_nxt  = S_VAL;
              end
            end
            ACT_SINGLE: begin
              fin           = 1'b1;
              root_leaf_nxt = 1'b1;
              root_sym_nxt  = in_data.symbol_index;
              walk_nxt      = '0;
              ready_nxt     = 1'b1;
            end
            default: begin
              bit_nxt = in_data.code_bit;
              if (!ready_r) begin
                fin        = 1'b1;
                res.status = STAT_NO_TREE;
              end else if (root_leaf_r) begin
                fin              = 1'b1;
                res.symbol_valid = 1'b1;
                res.symbol       = root_sym_r;
              end else begin
                state_nxt = S_DEC_WAIT;
              end
            end
          endcase
        end
      end

      S_VAL: begin
        // Scaled Kraft sum; an over-full depth also overshoots the target
        if (i_r == end_r) begin
          if (sum_r == target) begin
            i_nxt     = '0;
            state_nxt = S_CHAIN;
          end else begin
            fin        = 1'b1;
            res.status = STAT_BAD;
            state_nxt  = S_IDLE;
          end
        end else if (len_cur > maxd_r) begin
          fin        = 1'b1;
          res.status = STAT_BAD;
          state_nxt  = S_IDLE;
        end else begin
          if (len_cur >= mind_r) sum_nxt = sum_r + term;
          i_nxt = i_r + 6'd1;
        end
      end

      S_CHAIN: begin
        // Left spine down to min_depth - 1
        if (i8 + 8'd1 < {3'b000, mind_r}) begin
          if (i8 + 8'd1 >= NUM8) begin
            fin        = 1'b1;
            res.status = STAT_BAD;
            state_nxt  = S_IDLE;
          end else begin
            lc_we                = 1'b1;
            lc_node              = NI'(i_r);
            lc_wdata             = {1'b0, 7'(i_r + 6'd1)};
            lc_set_nxt[NI'(i_r)] = 1'b1;
            pn_we                = 1'b1;
            pn_waddr             = NI'(i_r + 6'd1);
            pn_wdata             = NI'(i_r);
            i_nxt                = i_r + 6'd1;
          end
        end else begin
          curr_nxt  = NW'(mind_r - 5'd1);
          empty_nxt = NW'(mind_r);
          d_nxt     = mind_r;
          i_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (i_r == end_r) begin
          // Close the depth: hang a fresh node at the current position
          if (curr_r >= NUMW || empty_r >= NUMW || d_r == maxd_r) begin
            fin        = 1'b1;
            res.status = STAT_BAD;
            state_nxt  = S_IDLE;
          end else begin
            if (!lc_set_r[curr_ix]) begin
              lc_we               = 1'b1;
              lc_wdata            = empty_val;
              lc_set_nxt[curr_ix] = 1'b1;
            end else begin
              rc_we               = 1'b1;
              rc_wdata            = empty_val;
              rc_set_nxt[curr_ix] = 1'b1;
            end
            pn_we     = 1'b1;
            curr_nxt  = empty_r;
            empty_nxt = e1;
            d_nxt     = d_r + 5'd1;
            i_nxt     = '0;
          end
        end else if (len_cur != d_r) begin
          i_nxt = i_r + 6'd1;
        end else if (curr_r >= NUMW) begin
          fin        = 1'b1;
          res.status = STAT_BAD;
          state_nxt  = S_IDLE;
        end else if (!lc_set_r[curr_ix]) begin
          lc_we               = 1'b1;
          lc_set_nxt[curr_ix] = 1'b1;
          i_nxt               = i_r + 6'd1;
        end else begin
          rc_we               = 1'b1;
          rc_set_nxt[curr_ix] = 1'b1;
          n_nxt               = '0;
          i_nxt               = i_r + 6'd1;
          state_nxt           = S_CLIMB;
        end
      end

      S_CLIMB: begin
        if (rc_set_r[curr_ix]) begin
          if (curr_r == '0) begin
            // Tree closed: commit the new bank
            fin           = 1'b1;
            bank_nxt      = ~bank_r;
            root_leaf_nxt = 1'b0;
            walk_nxt      = '0;
            ready_nxt     = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_CLIMB_WAIT;
          end
        end else if (empty_r >= NUMW) begin
          fin        = 1'b1;
          res.status = STAT_BAD;
          state_nxt  = S_IDLE;
        end else begin
          rc_we               = 1'b1;
          rc_wdata            = empty_val;
          rc_set_nxt[curr_ix] = 1'b1;
          state_nxt           = S_DESC;
        end
      end

      S_CLIMB_WAIT: begin
        curr_nxt  = NW'(pn_rdata);
        n_nxt     = n_r + NW'(1);
        state_nxt = S_CLIMB;
      end

      S_DESC: begin
        // Walk back down one level per cycle along fresh left children
        if (empty_r >= NUMW) begin
          fin        = 1'b1;
          res.status = STAT_BAD;
          state_nxt  = S_IDLE;
        end else begin
          pn_we     = 1'b1;
          curr_nxt  = empty_r;
          empty_nxt = e1;
          n_nxt     = n_r - NW'(1);
          if (n_r == NW'(1)) begin
            state_nxt = S_SCAN;
          end else if (e1 >= NUMW) begin
            fin        = 1'b1;
            res.status = STAT_BAD;
            state_nxt  = S_IDLE;
          end else begin
            lc_we                = 1'b1;
            lc_node              = empty_ix;
            lc_wdata             = {1'b0, 7'(e1)};
            lc_set_nxt[empty_ix] = 1'b1;
          end
        end
      end

      S_DEC_WAIT: begin
        fin          = 1'b1;
        res.bit_used = 1'b1;
        state_nxt    = S_IDLE;
        if (child[LEAF_BIT]) begin
          res.symbol_valid = 1'b1;
          res.symbol       = child[4:0];
          walk_nxt         = '0;
        end else begin
          walk_nxt = child[NI-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
      root_leaf_r <= 1'b0;
      root_sym_r  <= '0;
      walk_r      <= '0;
      bank_r      <= 1'b0;
      lc_set_r    <= '0;
      rc_set_r    <= '0;
      for (int k = 0; k < LEN_ENTRIES; k++) len_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ready_r     <= ready_nxt;
      root_leaf_r <= root_leaf_nxt;
      root_sym_r  <= root_sym_nxt;
      walk_r      <= walk_nxt;
      bank_r      <= bank_nxt;
      lc_set_r    <= lc_set_nxt;
      rc_set_r    <= rc_set_nxt;
      len_r       <= len_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    end_r   <= end_nxt;
    d_r     <= d_nxt;
    mind_r  <= mind_nxt;
    maxd_r  <= maxd_nxt;
    bit_r   <= bit_nxt;
    curr_r  <= curr_nxt;
    empty_r <= empty_nxt;
    n_r     <= n_nxt;
    sum_r   <= sum_nxt;
    out_r   <= out_nxt;
  end

  // A finished beat never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // Input is taken only by the idle sequencer
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("ready outside idle");

  // Descend always has at least one level left
  a_desc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DESC) |-> (n_r != '0))
    else $error("descend with zero levels");

  // The current node always lies below the next free node
  a_curr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_CLIMB || state_r == S_DESC) |->
    (curr_r < empty_r))
    else $error("current node not below free node");

  // A decode walk result follows a committed tree
  a_walk_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC_WAIT) |-> (ready_r && !root_leaf_r))
    else $error("walk without built tree");

endmodule
